/* src/tpsi_pkg.sv */
// Shared types, constants and helpers of the terrain patch skirt indexer.
package tpsi_pkg;

   localparam int MAX_SIDE = 255;
   localparam int SIDE_W   = 8;
   localparam int IDX_W    = 17;
   localparam int CORNERS  = 6;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = SIDE_W;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [SIDE_W-1:0] side_type;

   // Section codes; the generator phase uses the same encoding.
   typedef enum logic [2:0] {
      SEC_SURFACE = 3'd0,
      SEC_NEAR    = 3'd1,
      SEC_FAR     = 3'd2,
      SEC_LEFT    = 3'd3,
      SEC_RIGHT   = 3'd4
   } section_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GRID_WIDTH  = 1'b0,
      REG_GRID_HEIGHT = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [CORNERS-1:0][IDX_W-1:0] corner;
      section_type                   section;
      logic                          quad_valid;
      logic                          last_quad;
   } quad_type;

   // A side of zero acts as one; anything above the maximum is clamped.
   function automatic side_type eff_side(input side_type v);
      side_type r;
      r = v;
      if (v == '0) begin
         r = side_type'(1);
      end else if (int'(v) > MAX_SIDE) begin
         r = side_type'(MAX_SIDE);
      end
      return r;
   endfunction

endpackage

/* src/tpsi_if.sv */
// Request and response channel interfaces of the terrain patch skirt indexer.
interface tpsi_req_if;
   import tpsi_pkg::*;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface tpsi_rsp_if;
   import tpsi_pkg::*;
   logic        valid;
   logic        ready;
   idx_type     corner_0;
   idx_type     corner_1;
   idx_type     corner_2;
   idx_type     corner_3;
   idx_type     corner_4;
   idx_type     corner_5;
   logic [2:0]  section;
   logic        quad_valid;
   logic        last_quad;

   modport source (output valid, output corner_0, output corner_1, output corner_2,
                   output corner_3, output corner_4, output corner_5, output section,
                   output quad_valid, output last_quad, input ready);
   modport sink   (input valid, input corner_0, input corner_1, input corner_2,
                   input corner_3, input corner_4, input corner_5, input section,
                   input quad_valid, input last_quad, output ready);
endinterface

/* src/terrain_patch_skirt_indexer_top.sv */
// Top level of the terrain patch skirt indexer: configuration, handshake and output register.
// The block emits the triangle index list of a W by H grid patch closed by a skirt on all
// four borders, one quad (two triangles, six vertex indices) per request word. Quads come
// surface first, row by row, then the near, far, left and right skirts; skirt vertices are
// numbered after the (W+1)(H+1) surface vertices. A request with restart set jumps back to
// the first surface quad and emits it in the same word; after the quad flagged last_quad,
// further advances return a word with quad_valid low and all other fields zero. For each
// request word the quad is formed by a few additions from the walker's counters and running
// base indices and lands in the response register, so a new word is accepted every cycle
// while the response side keeps taking words. The response register frees itself in the
// cycle the sink takes its word, so a new word can be accepted in that same cycle.
// Writing either grid register restarts the patch; writes should be made while no response
// is outstanding. A side of zero is treated as one.
module terrain_patch_skirt_indexer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [tpsi_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tpsi_pkg::CSR_DATA_W-1:0]     csr_write_data,
   tpsi_req_if.sink                            req_if,
   tpsi_rsp_if.source                          rsp_if
);
   import tpsi_pkg::*;

   side_type  grid_width_ff;
   side_type  grid_height_ff;
   logic      rsp_valid_ff;
   quad_type  rsp_word_ff;
   quad_type  quad;
   logic      accept;

   // Grid registers; any write to them also clears the walker.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= side_type'(16);
         grid_height_ff <= side_type'(16);
      end else if (csr_write_en) begin
         case (csr_reg_type'(csr_index))
            REG_GRID_WIDTH:  grid_width_ff  <= csr_write_data;
            REG_GRID_HEIGHT: grid_height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // The request side is open whenever the response register is empty or being drained.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   tpsi_quad_gen u_quad_gen (
      .clock   (clock),
      .reset   (reset),
      .clear   (csr_write_en),
      .step    (accept),
      .restart (req_if.restart),
      .grid_w  (eff_side(grid_width_ff)),
      .grid_h  (eff_side(grid_height_ff)),
      .quad    (quad)
   );

   // Response register: valid is control state, the word itself needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= quad;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.corner_0   = rsp_word_ff.corner[0];
   assign rsp_if.corner_1   = rsp_word_ff.corner[1];
   assign rsp_if.corner_2   = rsp_word_ff.corner[2];
   assign rsp_if.corner_3   = rsp_word_ff.corner[3];
   assign rsp_if.corner_4   = rsp_word_ff.corner[4];
   assign rsp_if.corner_5   = rsp_word_ff.corner[5];
   assign rsp_if.section    = rsp_word_ff.section;
   assign rsp_if.quad_valid = rsp_word_ff.quad_valid;
   assign rsp_if.last_quad  = rsp_word_ff.last_quad;

endmodule

/* src/tpsi_quad_gen.sv */
// Quad walker: section state, counters, running bases and the corner arithmetic.
module tpsi_quad_gen (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic               step,
   input  logic               restart,
   input  tpsi_pkg::side_type grid_w,
   input  tpsi_pkg::side_type grid_h,
   output tpsi_pkg::quad_type quad
);
   import tpsi_pkg::*;

   section_type phase_ff, phase_in;
   side_type    row_ff, row_in;
   side_type    col_ff, col_in;
   idx_type     surf_ff, surf_in;
   idx_type     skirt_ff, skirt_in;
   logic        finished_ff, finished_in;

   section_type phase_c;
   side_type    row_c, col_c;
   idx_type     surf_c, skirt_c;
   logic        finished_c;

   logic [SIDE_W:0] col_next;
   logic [SIDE_W:0] row_next;
   logic            col_end_w, col_end_h, row_end;
   idx_type         vw, s, j;

   always_comb begin
      // A restart takes effect before the quad of this word is formed.
      phase_c    = restart ? SEC_SURFACE : phase_ff;
      row_c      = restart ? '0 : row_ff;
      col_c      = restart ? '0 : col_ff;
      surf_c     = restart ? '0 : surf_ff;
      skirt_c    = restart ? '0 : skirt_ff;
      finished_c = restart ? 1'b0 : finished_ff;

      vw        = IDX_W'(grid_w) + IDX_W'(1);
      j         = IDX_W'(col_c);
      col_next  = {1'b0, col_c} + (SIDE_W+1)'(1);
      row_next  = {1'b0, row_c} + (SIDE_W+1)'(1);
      col_end_w = col_next >= {1'b0, grid_w};
      col_end_h = col_next >= {1'b0, grid_h};
      row_end   = row_next >= {1'b0, grid_h};
      s         = surf_c;

      phase_in    = phase_c;
      row_in      = row_c;
      col_in      = col_next[SIDE_W-1:0];
      surf_in     = surf_c;
      skirt_in    = skirt_c + IDX_W'(1);
      finished_in = finished_c;

      quad            = '0;
      quad.section    = phase_c;
      quad.quad_valid = 1'b1;

      case (phase_c)
         SEC_SURFACE: begin
            quad.corner = {s + vw + IDX_W'(1), s + IDX_W'(1), s + vw,
                           s + vw, s + IDX_W'(1), s};
            skirt_in = skirt_c;
            surf_in  = s + IDX_W'(1);
            if (col_end_w) begin
               col_in  = '0;
               surf_in = s + IDX_W'(2);
               row_in  = row_next[SIDE_W-1:0];
               if (row_end) begin
                  // First skirt vertex follows the (W+1)(H+1) surface vertices.
                  phase_in = SEC_NEAR;
                  skirt_in = s + IDX_W'(2) + vw;
               end
            end
         end
         SEC_NEAR: begin
            quad.corner = {j + IDX_W'(1), skirt_c + IDX_W'(1), j,
                           j, skirt_c + IDX_W'(1), skirt_c};
            if (col_end_w) begin
               col_in   = '0;
               skirt_in = skirt_c + IDX_W'(2);
               phase_in = SEC_FAR;
            end
         end
         SEC_FAR: begin
            s = surf_c + j;
            quad.corner = {s, skirt_c, s + IDX_W'(1),
                           s + IDX_W'(1), skirt_c, skirt_c + IDX_W'(1)};
            if (col_end_w) begin
               col_in   = '0;
               skirt_in = skirt_c + IDX_W'(2);
               surf_in  = '0;
               phase_in = SEC_LEFT;
            end
         end
         SEC_LEFT: begin
            quad.corner = {s, skirt_c, s + vw,
                           s + vw, skirt_c, skirt_c + IDX_W'(1)};
            surf_in = s + vw;
            if (col_end_h) begin
               col_in   = '0;
               skirt_in = skirt_c + IDX_W'(2);
               surf_in  = IDX_W'(grid_w);
               phase_in = SEC_RIGHT;
            end
         end
         default: begin
            quad.corner = {s + vw, skirt_c + IDX_W'(1), s,
                           s, skirt_c + IDX_W'(1), skirt_c};
            surf_in = s + vw;
            if (col_end_h) begin
               quad.last_quad = 1'b1;
               finished_in    = 1'b1;
            end
         end
      endcase

      // Once the patch is done the state holds and the word is all zeros.
      if (finished_c) begin
         quad        = '0;
         phase_in    = phase_c;
         row_in      = row_c;
         col_in      = col_c;
         surf_in     = surf_c;
         skirt_in    = skirt_c;
         finished_in = finished_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         phase_ff    <= SEC_SURFACE;
         row_ff      <= '0;
         col_ff      <= '0;
         surf_ff     <= '0;
         skirt_ff    <= '0;
         finished_ff <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         surf_ff     <= surf_in;
         skirt_ff    <= skirt_in;
         finished_ff <= finished_in;
      end
   end

endmodule
